@@ src/npba_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package npba_pkg;

   // Pool and port geometry.
   localparam int NUM_POOLS      = 54;
   localparam int PORT_RANGE     = 1024;
   localparam int POOL_W         = 6;
   localparam int PORT_W         = 10;
   localparam int EXT_ADDR_W     = 32;

   // Bitmap layout: one bit per port, one memory word per 64 ports.
   localparam int WORD_BITS      = 64;
   localparam int BIT_IDX_W      = $clog2(WORD_BITS);
   localparam int WORDS_PER_POOL = PORT_RANGE / WORD_BITS;
   localparam int WORD_IDX_W     = $clog2(WORDS_PER_POOL);
   localparam int MEM_ADDR_W     = POOL_W + WORD_IDX_W;
   localparam int MEM_DEPTH      = NUM_POOLS * WORDS_PER_POOL;

   // The scan visits every word of a pool once and the start word a second time.
   localparam int LAST_STEP      = WORDS_PER_POOL;
   localparam int STEP_W         = $clog2(LAST_STEP + 1);

   // Find-first-one is split into groups of bits.
   localparam int GROUP_BITS     = 8;
   localparam int NUM_GROUPS     = WORD_BITS / GROUP_BITS;
   localparam int GROUP_IDX_W    = $clog2(NUM_GROUPS);
   localparam int GBIT_IDX_W     = $clog2(GROUP_BITS);

   // Stream widths.
   localparam int REQ_DATA_W     = 16;
   localparam int RSP_DATA_W     = 48;

   typedef logic [WORD_BITS-1:0]  word_type;
   typedef logic [MEM_ADDR_W-1:0] mem_addr_type;

   // Write command toward the bitmap memory.
   typedef struct packed {
      logic         en;
      mem_addr_type addr;
      word_type     data;
   } mem_wr_type;

   // Read command toward the bitmap memory.
   typedef struct packed {
      logic         en;
      mem_addr_type addr;
   } mem_rd_type;

   typedef enum logic [3:0] {
      ST_CLEAR  = 4'b0001,
      ST_IDLE   = 4'b0010,
      ST_SCAN   = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   // External IPv4 address of each pool, first octet in the top byte.
   function automatic logic [EXT_ADDR_W-1:0] pool_address(input logic [POOL_W-1:0] pool);
      logic [EXT_ADDR_W-1:0] addr;
      case (pool)
         6'd0:    addr = 32'h0A000001;
         6'd1:    addr = 32'h0A00000A;
         6'd2:    addr = 32'h0A000064;
         6'd3:    addr = 32'h01000001;
         6'd4:    addr = 32'h0100000A;
         6'd5:    addr = 32'h01000064;
         6'd6:    addr = 32'h0A000101;
         6'd7:    addr = 32'h0A000A0A;
         6'd8:    addr = 32'h0A006464;
         6'd9:    addr = 32'h01000101;
         6'd10:   addr = 32'h01000A0A;
         6'd11:   addr = 32'h01006464;
         6'd12:   addr = 32'h0A010101;
         6'd13:   addr = 32'h0A0A0A0A;
         6'd14:   addr = 32'h0A646464;
         6'd15:   addr = 32'h01010101;
         6'd16:   addr = 32'h010A0A0A;
         6'd17:   addr = 32'h01646464;
         6'd18:   addr = 32'hAC100001;
         6'd19:   addr = 32'hAC10000A;
         6'd20:   addr = 32'hAC100064;
         6'd21:   addr = 32'h11100001;
         6'd22:   addr = 32'h1110000A;
         6'd23:   addr = 32'h11100064;
         6'd24:   addr = 32'hAC100101;
         6'd25:   addr = 32'hAC100A0A;
         6'd26:   addr = 32'hAC106464;
         6'd27:   addr = 32'h11100101;
         6'd28:   addr = 32'h11100A0A;
         6'd29:   addr = 32'h11106464;
         6'd30:   addr = 32'hACA00001;
         6'd31:   addr = 32'hACA0000A;
         6'd32:   addr = 32'hACA00064;
         6'd33:   addr = 32'h11A00001;
         6'd34:   addr = 32'h11A0000A;
         6'd35:   addr = 32'h11A00064;
         6'd36:   addr = 32'hC0000A01;
         6'd37:   addr = 32'hC00A0A0A;
         6'd38:   addr = 32'hC0640A64;
         6'd39:   addr = 32'h13000A01;
         6'd40:   addr = 32'h130A0A0A;
         6'd41:   addr = 32'h13640A64;
         6'd42:   addr = 32'hC0A80A01;
         6'd43:   addr = 32'hC0A80A0A;
         6'd44:   addr = 32'hC0A80A64;
         6'd45:   addr = 32'h13A80A01;
         6'd46:   addr = 32'h13A80A0A;
         6'd47:   addr = 32'h13A80A64;
         6'd48:   addr = 32'hC0A86401;
         6'd49:   addr = 32'hC0A8640A;
         6'd50:   addr = 32'hC0A86464;
         6'd51:   addr = 32'h13A86401;
         6'd52:   addr = 32'h13A8640A;
         6'd53:   addr = 32'h13A86464;
         default: addr = '0;
      endcase
      return addr;
   endfunction

endpackage

`default_nettype wire

@@ src/npba_bitmap_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module npba_bitmap_ram (
   input  wire                   clock,
   input  npba_pkg::mem_wr_type  wr_i,
   input  npba_pkg::mem_rd_type  rd_i,
   output npba_pkg::word_type    rd_data_o
);
   import npba_pkg::*;

   word_type mem [MEM_DEPTH];
   word_type rd_data_ff;

   // Single write port.
   always_ff @(posedge clock) begin
      if (wr_i.en) begin
         mem[wr_i.addr] <= wr_i.data;
      end
   end

   // Registered read port; the read data appears in the cycle after the read.
   always_ff @(posedge clock) begin
      if (rd_i.en) begin
         rd_data_ff <= mem[rd_i.addr];
      end
   end

   assign rd_data_o = rd_data_ff;

endmodule

`default_nettype wire

@@ src/npba_first_free.sv @@
`timescale 1ns / 1ps
`default_nettype none

module npba_first_free (
   input  npba_pkg::word_type             word_i,
   output logic                           hit_o,
   output logic [npba_pkg::BIT_IDX_W-1:0] index_o
);
   import npba_pkg::*;

   logic [NUM_GROUPS-1:0]  grp_any;
   logic [GROUP_IDX_W-1:0] grp_sel;
   logic [GROUP_BITS-1:0]  grp_bits;
   logic [GBIT_IDX_W-1:0]  bit_sel;

   // Flag every group of bits that holds a free port.
   always_comb begin
      for (int g = 0; g < NUM_GROUPS; g++) begin
         grp_any[g] = |word_i[g*GROUP_BITS +: GROUP_BITS];
      end
   end

   // Lowest group with a free port, then the lowest bit inside it.
   always_comb begin
      grp_sel = '0;
      for (int g = NUM_GROUPS - 1; g >= 0; g--) begin
         if (grp_any[g]) begin
            grp_sel = GROUP_IDX_W'(g);
         end
      end
      grp_bits = word_i[grp_sel*GROUP_BITS +: GROUP_BITS];
      bit_sel = '0;
      for (int b = GROUP_BITS - 1; b >= 0; b--) begin
         if (grp_bits[b]) begin
            bit_sel = GBIT_IDX_W'(b);
         end
      end
   end

   assign hit_o   = |grp_any;
   assign index_o = {grp_sel, bit_sel};

endmodule

`default_nettype wire

@@ src/nat_port_bitmap_allocator.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Each item starts a scan of its pool's bitmap, one word per cycle, from the start word upward,
// wrapping within the pool, until a free port turns up or the start word has been read a
// second time; a pool out of range answers without a scan. No new item is taken until the
// result of the last one has moved into the response register.
// Reset: synchronous; afterwards a pass writes all 864 bitmap words to all free,
// during which no item is accepted.
module nat_port_bitmap_allocator (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_tvalid,
   output logic                               req_tready,
   input  wire  [npba_pkg::REQ_DATA_W-1:0]    req_tdata,  // pool_index[5:0], first_port[15:6]
   output logic                               rsp_tvalid,
   input  wire                                rsp_tready,
   output logic [npba_pkg::RSP_DATA_W-1:0]    rsp_tdata,  // ext_address[31:0], ext_port[41:32]
   output logic                               rsp_tuser   // found
);
   import npba_pkg::*;

   state_type               state_ff, state_in;
   mem_addr_type            clr_ff, clr_in;
   logic [POOL_W-1:0]       pool_ff, pool_in;
   logic [PORT_W-1:0]       start_ff, start_in;
   logic [STEP_W-1:0]       cnt_ff, cnt_in;
   logic                    chk_valid_ff, chk_valid_in;
   logic [STEP_W-1:0]       chk_step_ff, chk_step_in;
   logic [WORD_IDX_W-1:0]   chk_word_ff, chk_word_in;
   logic                    res_found_ff, res_found_in;
   logic [EXT_ADDR_W-1:0]   res_addr_ff, res_addr_in;
   logic [PORT_W-1:0]       res_port_ff, res_port_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_found_ff, rsp_found_in;
   logic [EXT_ADDR_W-1:0]   rsp_addr_ff, rsp_addr_in;
   logic [PORT_W-1:0]       rsp_port_ff, rsp_port_in;

   mem_wr_type              mem_wr;
   mem_rd_type              mem_rd;
   word_type                rd_data;
   word_type                scan_mask;
   word_type                masked;
   logic                    hit;
   logic [BIT_IDX_W-1:0]    hit_idx;
   logic [WORD_IDX_W-1:0]   start_word;
   logic [BIT_IDX_W-1:0]    start_bit;
   logic [WORD_IDX_W-1:0]   rd_word;
   logic [POOL_W-1:0]       req_pool;
   logic [PORT_W-1:0]       req_first;

   npba_bitmap_ram u_ram (
      .clock     (clock),
      .wr_i      (mem_wr),
      .rd_i      (mem_rd),
      .rd_data_o (rd_data)
   );

   npba_first_free u_find (
      .word_i  (masked),
      .hit_o   (hit),
      .index_o (hit_idx)
   );

   assign req_pool   = req_tdata[POOL_W-1:0];
   assign req_first  = req_tdata[POOL_W +: PORT_W];
   assign start_word = start_ff[PORT_W-1:BIT_IDX_W];
   assign start_bit  = start_ff[BIT_IDX_W-1:0];
   assign rd_word    = start_word + cnt_ff[WORD_IDX_W-1:0];

   // The first visit of the start word looks at ports from the start upward, the second
   // visit at the ports below the start.
   always_comb begin
      if (chk_step_ff == '0) begin
         scan_mask = {WORD_BITS{1'b1}} << start_bit;
      end else if (chk_step_ff == STEP_W'(LAST_STEP)) begin
         scan_mask = ~({WORD_BITS{1'b1}} << start_bit);
      end else begin
         scan_mask = {WORD_BITS{1'b1}};
      end
      masked = rd_data & scan_mask;
   end

   // Sequencer: clearing pass, request intake, pipelined word scan, result hand-off.
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      pool_in      = pool_ff;
      start_in     = start_ff;
      cnt_in       = cnt_ff;
      chk_valid_in = 1'b0;
      chk_step_in  = chk_step_ff;
      chk_word_in  = chk_word_ff;
      res_found_in = res_found_ff;
      res_addr_in  = res_addr_ff;
      res_port_in  = res_port_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_found_in = rsp_found_ff;
      rsp_addr_in  = rsp_addr_ff;
      rsp_port_in  = rsp_port_ff;
      mem_wr       = '0;
      mem_rd.en    = 1'b0;
      mem_rd.addr  = {pool_ff, rd_word};

      case (state_ff)
         ST_CLEAR: begin
            mem_wr.en   = 1'b1;
            mem_wr.addr = clr_ff;
            mem_wr.data = {WORD_BITS{1'b1}};
            clr_in      = clr_ff + 1'b1;
            if (clr_ff == MEM_ADDR_W'(MEM_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               pool_in  = req_pool;
               start_in = req_first;
               cnt_in   = '0;
               if ({1'b0, req_pool} < (POOL_W + 1)'(NUM_POOLS)) begin
                  state_in = ST_SCAN;
               end else begin
                  res_found_in = 1'b0;
                  res_addr_in  = '0;
                  res_port_in  = '0;
                  state_in     = ST_FINISH;
               end
            end
         end
         ST_SCAN: begin
            // Issue one word read per cycle.
            if (cnt_ff <= STEP_W'(LAST_STEP)) begin
               mem_rd.en    = 1'b1;
               cnt_in       = cnt_ff + 1'b1;
               chk_valid_in = 1'b1;
               chk_step_in  = cnt_ff;
               chk_word_in  = rd_word;
            end
            // Check the word read in the previous cycle.
            if (chk_valid_ff) begin
               if (hit) begin
                  mem_wr.en    = 1'b1;
                  mem_wr.addr  = {pool_ff, chk_word_ff};
                  mem_wr.data  = rd_data & ~(word_type'(1) << hit_idx);
                  res_found_in = 1'b1;
                  res_addr_in  = pool_address(pool_ff);
                  res_port_in  = {chk_word_ff, hit_idx};
                  chk_valid_in = 1'b0;
                  state_in     = ST_FINISH;
               end else if (chk_step_ff == STEP_W'(LAST_STEP)) begin
                  res_found_in = 1'b0;
                  res_addr_in  = '0;
                  res_port_in  = '0;
                  chk_valid_in = 1'b0;
                  state_in     = ST_FINISH;
               end
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = res_found_ff;
               rsp_addr_in  = res_addr_ff;
               rsp_port_in  = res_port_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         chk_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         chk_valid_ff <= chk_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      pool_ff      <= pool_in;
      start_ff     <= start_in;
      cnt_ff       <= cnt_in;
      chk_step_ff  <= chk_step_in;
      chk_word_ff  <= chk_word_in;
      res_found_ff <= res_found_in;
      res_addr_ff  <= res_addr_in;
      res_port_ff  <= res_port_in;
      rsp_found_ff <= rsp_found_in;
      rsp_addr_ff  <= rsp_addr_in;
      rsp_port_ff  <= rsp_port_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_found_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - EXT_ADDR_W - PORT_W){1'b0}}, rsp_port_ff, rsp_addr_ff};

endmodule

`default_nettype wire
